// File: design/brcc_pkg.sv
// shared types, constants and register codes for the balancing robot controller
// no dependencies; imported by every module of the block
package brcc_pkg;

    // field widths
    localparam int ANGLE_W  = 17;
    localparam int GAIN_W   = 32;
    localparam int RATE_W   = 16;
    localparam int WHEEL_W  = 20;
    localparam int DUTY_W   = 13;
    localparam int CFG_IDX_W = 3;

    // internal widths
    localparam int ERR_W    = 19;
    localparam int FILT_W   = 22;
    localparam int INTEG_W  = 15;
    localparam int ISUM_W   = 23;
    localparam int MAG_W    = 24;
    localparam int MULB_W   = 25;
    localparam int PROD_W   = 57;
    localparam int ACC_W    = 58;
    localparam int TERM_W   = 42;
    localparam int UPR_W    = 34;
    localparam int BASE_W   = 44;
    localparam int CMD_W    = 14;
    localparam int STEP_W   = 4;

    // limits
    localparam int DUTY_LIMIT     = 7200;
    localparam int INTEGRAL_LIMIT = 8000;
    localparam int FALL_LIMIT     = 20480;

    // divide by five: multiply by ceil(2^26/5), keep bits above 26
    localparam logic signed [GAIN_W-1:0] RECIP5 = 32'sd13421773;
    localparam int RECIP_SHIFT = 26;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KD     = 3'd7;

    // configuration reset values
    localparam logic signed [ANGLE_W-1:0] RST_ZERO_ANGLE  = 17'sd1608;
    localparam logic signed [ANGLE_W-1:0] RST_ZERO_OFFSET = 17'sd0;
    localparam logic signed [GAIN_W-1:0]  RST_ANGLE_KP    = -32'sd40632320;
    localparam logic signed [GAIN_W-1:0]  RST_ANGLE_KD    = 32'sd110100;
    localparam logic signed [GAIN_W-1:0]  RST_SPEED_KP    = -32'sd1048576;
    localparam logic signed [GAIN_W-1:0]  RST_SPEED_KI    = -32'sd5243;
    localparam logic signed [GAIN_W-1:0]  RST_TURN_KP     = 32'sd65536;
    localparam logic signed [GAIN_W-1:0]  RST_TURN_KD     = 32'sd0;

    // multiplier operand selects
    localparam logic [2:0] MUL_AD   = 3'd0;
    localparam logic [2:0] MUL_AP   = 3'd1;
    localparam logic [2:0] MUL_TURN = 3'd2;
    localparam logic [2:0] MUL_R4F  = 3'd3;
    localparam logic [2:0] MUL_RX   = 3'd4;
    localparam logic [2:0] MUL_SP   = 3'd5;
    localparam logic [2:0] MUL_SI   = 3'd6;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic signed [ANGLE_W-1:0] zero_angle;
        logic signed [ANGLE_W-1:0] zero_offset;
        logic signed [GAIN_W-1:0]  angle_kp;
        logic signed [GAIN_W-1:0]  angle_kd;
        logic signed [GAIN_W-1:0]  speed_kp;
        logic signed [GAIN_W-1:0]  speed_ki;
        logic signed [GAIN_W-1:0]  turn_kp;
        logic signed [GAIN_W-1:0]  turn_kd;
    } brcc_cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       pre_en;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic [1:0] acc_op;
        logic       acc_shift8;
        logic       upright_en;
        logic       turn_en;
        logic       a_en;
        logic       x_en;
        logic       filt_en;
        logic       integ_en;
        logic       integ_clr;
        logic       speed_en;
        logic       base_en;
        logic       cmd_en;
        logic       out_load;
    } brcc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
    } brcc_status_t;

endpackage

// File: design/balance_robot_cascade_control.sv
// top level of the two-wheel balancing robot cascade controller (PD upright, PI speed, turn)
// depends on brcc_pkg, brcc_cfg_regs, brcc_ctrl, brcc_datapath
//
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    pitch_angle .. turn_target
// result    out        out_valid / out_stall  drive_a_duty .. fallen
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item is registered at its transfer; no new item is taken until its result is
// in the output register, as the single shared 32x25 multiplier steps through
// seven products, two of them dependent divide-by-five steps of the filter.
// reset clears the filter state, the integral and the control; gains return
// to their defaults. a result waits in the output register under out_stall while
// the next item is taken; the following one then holds at its last step.
module balance_robot_cascade_control
    import brcc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [ANGLE_W-1:0]  pitch_angle,
    input  logic signed [RATE_W-1:0]   pitch_rate,
    input  logic signed [RATE_W-1:0]   yaw_rate,
    input  logic signed [WHEEL_W-1:0]  left_speed,
    input  logic signed [WHEEL_W-1:0]  right_speed,
    input  logic signed [RATE_W-1:0]   speed_target,
    input  logic signed [RATE_W-1:0]   turn_target,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [DUTY_W-1:0]          drive_a_duty,
    output logic                       drive_a_forward,
    output logic [DUTY_W-1:0]          drive_b_duty,
    output logic                       drive_b_forward,
    output logic                       fallen,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data
);

    brcc_cfg_t    cfg;
    brcc_cmd_t    cmd;
    brcc_status_t status;

    // configuration registers
    brcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    brcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and output register
    brcc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .pitch_angle     (pitch_angle),
        .pitch_rate      (pitch_rate),
        .yaw_rate        (yaw_rate),
        .left_speed      (left_speed),
        .right_speed     (right_speed),
        .speed_target    (speed_target),
        .turn_target     (turn_target),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .drive_a_duty    (drive_a_duty),
        .drive_a_forward (drive_a_forward),
        .drive_b_duty    (drive_b_duty),
        .drive_b_forward (drive_b_forward),
        .fallen          (fallen)
    );

endmodule

// File: design/brcc_cfg_regs.sv
// configuration register file of the balancing robot controller
// depends on brcc_pkg
module brcc_cfg_regs
    import brcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    output brcc_cfg_t            cfg
);

    brcc_cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register write on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_angle  <= RST_ZERO_ANGLE;
            cfg_reg.zero_offset <= RST_ZERO_OFFSET;
            cfg_reg.angle_kp    <= RST_ANGLE_KP;
            cfg_reg.angle_kd    <= RST_ANGLE_KD;
            cfg_reg.speed_kp    <= RST_SPEED_KP;
            cfg_reg.speed_ki    <= RST_SPEED_KI;
            cfg_reg.turn_kp     <= RST_TURN_KP;
            cfg_reg.turn_kd     <= RST_TURN_KD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ZERO_ANGLE:  cfg_reg.zero_angle  <= signed'(cfg_data[ANGLE_W-1:0]);
                REG_ZERO_OFFSET: cfg_reg.zero_offset <= signed'(cfg_data[ANGLE_W-1:0]);
                REG_ANGLE_KP:    cfg_reg.angle_kp    <= signed'(cfg_data);
                REG_ANGLE_KD:    cfg_reg.angle_kd    <= signed'(cfg_data);
                REG_SPEED_KP:    cfg_reg.speed_kp    <= signed'(cfg_data);
                REG_SPEED_KI:    cfg_reg.speed_ki    <= signed'(cfg_data);
                REG_TURN_KP:     cfg_reg.turn_kp     <= signed'(cfg_data);
                REG_TURN_KD:     cfg_reg.turn_kd     <= signed'(cfg_data);
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// File: design/brcc_datapath.sv
// datapath: input capture, shared multiplier, accumulator, filter, integral, output register
// depends on brcc_pkg; driven by brcc_ctrl
module brcc_datapath
    import brcc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  brcc_cfg_t                  cfg,
    input  brcc_cmd_t                  cmd,
    output brcc_status_t               status,
    input  logic signed [ANGLE_W-1:0]  pitch_angle,
    input  logic signed [RATE_W-1:0]   pitch_rate,
    input  logic signed [RATE_W-1:0]   yaw_rate,
    input  logic signed [WHEEL_W-1:0]  left_speed,
    input  logic signed [WHEEL_W-1:0]  right_speed,
    input  logic signed [RATE_W-1:0]   speed_target,
    input  logic signed [RATE_W-1:0]   turn_target,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [DUTY_W-1:0]          drive_a_duty,
    output logic                       drive_a_forward,
    output logic [DUTY_W-1:0]          drive_b_duty,
    output logic                       drive_b_forward,
    output logic                       fallen
);

    // captured item
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [RATE_W-1:0]  prate_reg;
    logic signed [RATE_W-1:0]  yrate_reg;
    logic signed [WHEEL_W-1:0] lspd_reg;
    logic signed [WHEEL_W-1:0] rspd_reg;
    logic signed [RATE_W-1:0]  starget_reg;
    logic signed [RATE_W-1:0]  ttarget_reg;

    // working registers
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [FILT_W-1:0]  lerr_reg;
    logic                      fallen_reg;
    logic [MAG_W-1:0]          fmag_reg;
    logic                      fneg_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [UPR_W-1:0]   upright_reg;
    logic signed [TERM_W-1:0]  turn_term_reg;
    logic signed [TERM_W-1:0]  speed_reg;
    logic signed [FILT_W-1:0]  a_reg;
    logic [MAG_W-1:0]          xmag_reg;
    logic                      xneg_reg;
    logic signed [BASE_W-1:0]  base_reg;
    logic signed [CMD_W-1:0]   cmd_a_reg;
    logic signed [CMD_W-1:0]   cmd_b_reg;

    // loop state
    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // output register
    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         duty_a_reg;
    logic                      fwd_a_reg;
    logic [DUTY_W-1:0]         duty_b_reg;
    logic                      fwd_b_reg;
    logic                      out_fallen_reg;

    // next values
    logic signed [ERR_W-1:0]   err_next;
    logic signed [FILT_W-1:0]  lerr_next;
    logic                      fallen_next;
    logic signed [MAG_W-1:0]   four_f;
    logic [MAG_W-1:0]          fmag_next;
    logic signed [GAIN_W-1:0]  mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_in;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      round16;
    logic                      round24;
    logic signed [TERM_W-1:0]  acc_q16;
    logic signed [UPR_W-1:0]   acc_q24;
    logic signed [FILT_W-1:0]  quot;
    logic signed [FILT_W-1:0]  a_next;
    logic signed [FILT_W-1:0]  filt_next;
    logic signed [MULB_W-1:0]  x_sum;
    logic [MAG_W-1:0]          xmag_next;
    logic signed [ISUM_W-1:0]  integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [BASE_W-1:0]  base_next;
    logic signed [BASE_W-1:0]  sum_a;
    logic signed [BASE_W-1:0]  sum_b;
    logic signed [CMD_W-1:0]   cmd_a_next;
    logic signed [CMD_W-1:0]   cmd_b_next;
    logic signed [CMD_W-1:0]   abs_a;
    logic signed [CMD_W-1:0]   abs_b;
    logic                      out_valid_next;

    // saturate a wheel command to the duty limit, zero once fallen
    function automatic logic signed [CMD_W-1:0] clamp_duty(
        input logic signed [BASE_W-1:0] v,
        input logic                     down
    );
        logic signed [CMD_W-1:0] r;
        if (down)
            r = '0;
        else if (v > DUTY_LIMIT)
            r = CMD_W'(DUTY_LIMIT);
        else if (v < -DUTY_LIMIT)
            r = CMD_W'(-DUTY_LIMIT);
        else
            r = CMD_W'(v);
        return r;
    endfunction

    // pitch error, speed error, fall detect, magnitude of 4 * filtered error
    assign err_next    = ERR_W'(cfg.zero_angle) - ERR_W'(pitch_reg) + ERR_W'(cfg.zero_offset);
    assign lerr_next   = FILT_W'(lspd_reg) + FILT_W'(rspd_reg) - FILT_W'(starget_reg);
    assign fallen_next = (pitch_reg >= FALL_LIMIT) || (pitch_reg <= -FALL_LIMIT);
    assign four_f      = MAG_W'(filt_reg) <<< 2;
    assign fmag_next   = four_f[MAG_W-1] ? MAG_W'(-four_f) : MAG_W'(four_f);

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AD:
            begin
                mul_a = cfg.angle_kd;
                mul_b = MULB_W'(prate_reg);
            end
            MUL_AP:
            begin
                mul_a = cfg.angle_kp;
                mul_b = MULB_W'(err_reg);
            end
            MUL_TURN:
            begin
                if (ttarget_reg == '0)
                begin
                    mul_a = cfg.turn_kd;
                    mul_b = MULB_W'(yrate_reg);
                end
                else
                begin
                    mul_a = cfg.turn_kp;
                    mul_b = MULB_W'(ttarget_reg);
                end
            end
            MUL_R4F:
            begin
                mul_a = RECIP5;
                mul_b = signed'({1'b0, fmag_reg});
            end
            MUL_RX:
            begin
                mul_a = RECIP5;
                mul_b = signed'({1'b0, xmag_reg});
            end
            MUL_SP:
            begin
                mul_a = cfg.speed_kp;
                mul_b = MULB_W'(filt_reg);
            end
            MUL_SI:
            begin
                mul_a = cfg.speed_ki;
                mul_b = MULB_W'(integ_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // accumulator, derivative product enters scaled by 256
    assign acc_in = cmd.acc_shift8 ? (ACC_W'(prod_reg) <<< 8) : ACC_W'(prod_reg);

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = acc_in;
            ACC_ADD:  acc_next = acc_reg + acc_in;
            default:  acc_next = acc_reg;
        endcase
    end

    // truncation toward zero of the accumulator by 2^16 and 2^24
    assign round16 = acc_reg[ACC_W-1] && (|acc_reg[15:0]);
    assign round24 = acc_reg[ACC_W-1] && (|acc_reg[23:0]);
    assign acc_q16 = TERM_W'(acc_reg >>> 16) + TERM_W'(signed'({1'b0, round16}));
    assign acc_q24 = UPR_W'(acc_reg >>> 24) + UPR_W'(signed'({1'b0, round24}));

    // quotient of a magnitude by five, sign restored afterwards
    assign quot      = signed'({1'b0, prod_reg[RECIP_SHIFT+FILT_W-2:RECIP_SHIFT]});
    assign a_next    = fneg_reg ? -quot : quot;
    assign filt_next = xneg_reg ? -quot : quot;

    // 5a + new speed error, as magnitude and sign
    assign x_sum     = (MULB_W'(a_reg) <<< 2) + MULB_W'(a_reg) + MULB_W'(lerr_reg);
    assign xmag_next = x_sum[MULB_W-1] ? MAG_W'(-x_sum) : MAG_W'(x_sum);

    // integral update with clamp
    assign integ_sum = ISUM_W'(integ_reg) + ISUM_W'(filt_reg);

    always_comb
    begin
        if (integ_sum > INTEGRAL_LIMIT)
            integ_next = INTEG_W'(INTEGRAL_LIMIT);
        else if (integ_sum < -INTEGRAL_LIMIT)
            integ_next = INTEG_W'(-INTEGRAL_LIMIT);
        else
            integ_next = INTEG_W'(integ_sum);
    end

    // wheel commands
    assign base_next  = BASE_W'(upright_reg) + BASE_W'(speed_reg);
    assign sum_a      = base_reg + BASE_W'(turn_term_reg);
    assign sum_b      = base_reg - BASE_W'(turn_term_reg);
    assign cmd_a_next = clamp_duty(sum_a, fallen_reg);
    assign cmd_b_next = clamp_duty(sum_b, fallen_reg);
    assign abs_a      = cmd_a_reg[CMD_W-1] ? -cmd_a_reg : cmd_a_reg;
    assign abs_b      = cmd_b_reg[CMD_W-1] ? -cmd_b_reg : cmd_b_reg;

    // output slot handshake
    assign status.slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.filt_en)
                filt_reg <= filt_next;
            if (cmd.integ_en)
                integ_reg <= integ_next;
            else if (cmd.integ_clr && fallen_reg)
                integ_reg <= '0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pitch_reg   <= pitch_angle;
            prate_reg   <= pitch_rate;
            yrate_reg   <= yaw_rate;
            lspd_reg    <= left_speed;
            rspd_reg    <= right_speed;
            starget_reg <= speed_target;
            ttarget_reg <= turn_target;
        end
        if (cmd.pre_en)
        begin
            err_reg    <= err_next;
            lerr_reg   <= lerr_next;
            fallen_reg <= fallen_next;
            fmag_reg   <= fmag_next;
            fneg_reg   <= four_f[MAG_W-1];
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cmd.upright_en)
            upright_reg <= acc_q24;
        if (cmd.turn_en)
            turn_term_reg <= acc_q16;
        if (cmd.speed_en)
            speed_reg <= acc_q16;
        if (cmd.a_en)
            a_reg <= a_next;
        if (cmd.x_en)
        begin
            xmag_reg <= xmag_next;
            xneg_reg <= x_sum[MULB_W-1];
        end
        if (cmd.base_en)
            base_reg <= base_next;
        if (cmd.cmd_en)
        begin
            cmd_a_reg <= cmd_a_next;
            cmd_b_reg <= cmd_b_next;
        end
        if (cmd.out_load)
        begin
            duty_a_reg     <= abs_a[DUTY_W-1:0];
            fwd_a_reg      <= !cmd_a_reg[CMD_W-1];
            duty_b_reg     <= abs_b[DUTY_W-1:0];
            fwd_b_reg      <= cmd_b_reg[CMD_W-1];
            out_fallen_reg <= fallen_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_a_duty    = duty_a_reg;
    assign drive_a_forward = fwd_a_reg;
    assign drive_b_duty    = duty_b_reg;
    assign drive_b_forward = fwd_b_reg;
    assign fallen          = out_fallen_reg;

    // integral never leaves its clamp
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg <= INTEGRAL_LIMIT && integ_reg >= -INTEGRAL_LIMIT)
        else $error("speed integral out of range");

    // a fallen robot gets zero drive with the fixed direction bits
    a_fallen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fallen_reg |->
            drive_a_duty == '0 && drive_b_duty == '0 && fwd_a_reg && !fwd_b_reg)
        else $error("fallen result with nonzero drive");

    // duties respect the limit
    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> duty_a_reg <= DUTY_LIMIT && duty_b_reg <= DUTY_LIMIT)
        else $error("duty above limit");

endmodule

// File: design/brcc_ctrl.sv
// controller: sequences one item through the datapath over a fixed step list
// depends on brcc_pkg; commands brcc_datapath
module brcc_ctrl
    import brcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  brcc_status_t status,
    output brcc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // step list
    localparam logic [STEP_W-1:0] STEP_PRE       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_UPR_P     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TURN_MUL  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_UPR_TAKE  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TURN_TAKE = 4'd4;
    localparam logic [STEP_W-1:0] STEP_X         = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FILT_MUL  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FILT      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_INTEG     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SPD_I     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SPD_ADD   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_SPD_TAKE  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_BASE      = 4'd12;
    localparam logic [STEP_W-1:0] STEP_CMD       = 4'd13;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign in_stall = (state_reg != ST_IDLE);

    // state and step sequencing
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_PRE;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_CMD)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (status.slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_AD;
        cmd.acc_op  = ACC_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_valid;
            end
            ST_RUN:
            begin
                case (step_reg)
                    STEP_PRE:
                    begin
                        cmd.pre_en  = 1'b1;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_AD;
                    end
                    STEP_UPR_P:
                    begin
                        cmd.mul_en     = 1'b1;
                        cmd.mul_sel    = MUL_AP;
                        cmd.acc_op     = ACC_LOAD;
                        cmd.acc_shift8 = 1'b1;
                    end
                    STEP_TURN_MUL:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_TURN;
                        cmd.acc_op  = ACC_ADD;
                    end
                    STEP_UPR_TAKE:
                    begin
                        cmd.upright_en = 1'b1;
                        cmd.acc_op     = ACC_LOAD;
                        cmd.mul_en     = 1'b1;
                        cmd.mul_sel    = MUL_R4F;
                    end
                    STEP_TURN_TAKE:
                    begin
                        cmd.turn_en = 1'b1;
                        cmd.a_en    = 1'b1;
                    end
                    STEP_X:
                    begin
                        cmd.x_en = 1'b1;
                    end
                    STEP_FILT_MUL:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_RX;
                    end
                    STEP_FILT:
                    begin
                        cmd.filt_en = 1'b1;
                    end
                    STEP_INTEG:
                    begin
                        cmd.integ_en = 1'b1;
                        cmd.mul_en   = 1'b1;
                        cmd.mul_sel  = MUL_SP;
                    end
                    STEP_SPD_I:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_SI;
                        cmd.acc_op  = ACC_LOAD;
                    end
                    STEP_SPD_ADD:
                    begin
                        cmd.acc_op    = ACC_ADD;
                        cmd.integ_clr = 1'b1;
                    end
                    STEP_SPD_TAKE:
                    begin
                        cmd.speed_en = 1'b1;
                    end
                    STEP_BASE:
                    begin
                        cmd.base_en = 1'b1;
                    end
                    STEP_CMD:
                    begin
                        cmd.cmd_en = 1'b1;
                    end
                    default:
                    begin
                        cmd.acc_op = ACC_HOLD;
                    end
                endcase
            end
            ST_FINISH:
            begin
                cmd.out_load = status.slot_free;
            end
            default:
            begin
                cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // an accepted item starts at the first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == ST_RUN && step_reg == STEP_PRE)
        else $error("item accepted without starting the sequence");

    // a finished result waits while the output slot is taken
    a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && !status.slot_free |=> state_reg == ST_FINISH && !cmd.load_in)
        else $error("finished result dropped");

endmodule
